### sv/svd_back_substitution_macros.svh
// ----------------------------------------------------------------------------
// SVD back substitution assertion macros
// Property shorthands for the block's concurrent checks; compiled out with
// ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SVD_BACK_SUBSTITUTION_MACROS_SVH
`define SVD_BACK_SUBSTITUTION_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SVDBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SVDBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SVDBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SVDBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/svdbs_pkg.sv
// ----------------------------------------------------------------------------
// SVD back substitution package
// Shared types, request codes and default sizes.
// ----------------------------------------------------------------------------
package svdbs_pkg;

    localparam int MAX_ROWS_DEF  = 512;
    localparam int MAX_MODES_DEF = 256;
    localparam int QDEPTH        = 4;

    // request codes on req_type
    localparam logic [1:0] REQ_WR_U   = 2'd0;
    localparam logic [1:0] REQ_WR_V   = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    // configuration register indices
    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_MODES = 2'd1;
    localparam logic [1:0] CFG_SHIFT = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WR_U,
        OP_WR_V,
        OP_SAMPLE,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [8:0]         row;
        logic [7:0]         col;
        logic signed [17:0] coef;
        logic signed [15:0] samp;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic clearing;
        logic solving;
    } back_status_t;

endpackage

### sv/svd_back_substitution.sv
// ----------------------------------------------------------------------------
// SVD back substitution top level
// Fixed-point x = V * (U' b) solver with coefficient load and result read.
// ----------------------------------------------------------------------------
// Request words are taken on start when busy is low and queued (four deep);
// the back end works them off in order. A U or V write is stored as it leaves
// the queue. A sample runs one multiply-accumulate per cycle, bound by the
// single read port of the U store. The last sample of a frame then runs the
// solve, one V coefficient per cycle through a split 18x48 multiplier. A read
// request puts its word on x_value/mode_index with done high for one cycle,
// the cycle right after it leaves the queue; done cannot be held off, so the
// receiver must take the word then. After reset a clearing pass zeroes every
// entry of the partial sums and solutions; busy stays high during it,
// configuration writes are taken as ever. Configuration must only be written
// while idle.
// ----------------------------------------------------------------------------
`include "svd_back_substitution_macros.svh"

module svd_back_substitution #(
    parameter int MAX_ROWS  = svdbs_pkg::MAX_ROWS_DEF,
    parameter int MAX_MODES = svdbs_pkg::MAX_MODES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          req_type,
    input  logic [8:0]          row_index,
    input  logic [7:0]          col_index,
    input  logic signed [17:0]  coef_value,
    input  logic signed [15:0]  sample_value,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [9:0]          cfg_data,
    output logic                done,
    output logic signed [23:0]  x_value,
    output logic [7:0]          mode_index
);
    import svdbs_pkg::*;

    logic [9:0]     rows_used_reg;
    logic [8:0]     modes_used_reg;
    logic [4:0]     out_shift_reg;

    item_t          q_item;
    logic           q_valid;
    logic           pop;
    q_status_t      qs;
    back_status_t   bs;

    // configuration registers; unknown indices are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg  <= 10'd512;
            modes_used_reg <= 9'd256;
            out_shift_reg  <= 5'd14;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS:  rows_used_reg  <= cfg_data;
                CFG_MODES: modes_used_reg <= cfg_data[8:0];
                CFG_SHIFT: out_shift_reg  <= cfg_data[4:0];
                default:   ;
            endcase
        end
    end

    // front: decode and queue
    svdbs_front #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_MODES (MAX_MODES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .row_index    (row_index),
        .col_index    (col_index),
        .coef_value   (coef_value),
        .sample_value (sample_value),
        .hold         (bs.clearing),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .pop          (pop),
        .qs           (qs)
    );

    // back: stores, MAC pipelines, result word
    svdbs_back #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_MODES (MAX_MODES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_item),
        .item_valid (q_valid),
        .pop        (pop),
        .rows_used  (rows_used_reg),
        .modes_used (modes_used_reg),
        .out_shift  (out_shift_reg),
        .done       (done),
        .x_value    (x_value),
        .mode_index (mode_index),
        .status     (bs)
    );

    `SVDBS_ASSERT_IMP(a_no_word_in_clear, clk, rst_n, done, !bs.clearing, "result word during clearing pass")
    `SVDBS_ASSERT_IMP(a_no_word_in_solve, clk, rst_n, done, !bs.solving, "result word while solving")
    `SVDBS_ASSERT_IMP(a_queue_flags, clk, rst_n, 1'b1, !(qs.full && qs.empty), "queue both full and empty")
    `SVDBS_ASSERT_NXT(a_clear_once, clk, rst_n, !bs.clearing, !bs.clearing, "clearing pass restarted")

endmodule

### sv/svdbs_front.sv
// ----------------------------------------------------------------------------
// SVD back substitution front end
// Takes request words, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module svdbs_front #(
    parameter int MAX_ROWS  = svdbs_pkg::MAX_ROWS_DEF,
    parameter int MAX_MODES = svdbs_pkg::MAX_MODES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          req_type,
    input  logic [8:0]          row_index,
    input  logic [7:0]          col_index,
    input  logic signed [17:0]  coef_value,
    input  logic signed [15:0]  sample_value,
    input  logic                hold,
    output svdbs_pkg::item_t    q_item,
    output logic                q_valid,
    input  logic                pop,
    output svdbs_pkg::q_status_t qs
);
    import svdbs_pkg::*;

    localparam int QPW = $clog2(QDEPTH);

    item_t              q_mem [QDEPTH];
    logic [QPW-1:0]     wr_ptr_reg;
    logic [QPW-1:0]     rd_ptr_reg;
    logic [QPW:0]       cnt_reg;
    logic               full;
    logic               accept;
    item_t              dec;

    assign full    = (cnt_reg == (QPW+1)'(QDEPTH));
    assign busy    = full || hold;
    assign accept  = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign q_item  = q_mem[rd_ptr_reg];
    assign qs.full  = full;
    assign qs.empty = !q_valid;

    // out-of-range writes turn into no-ops here
    always_comb
    begin
        dec.row  = row_index;
        dec.col  = col_index;
        dec.coef = coef_value;
        dec.samp = sample_value;
        case (req_type)
            REQ_WR_U:
                dec.op = (32'(row_index) < MAX_ROWS && 32'(col_index) < MAX_MODES)
                         ? OP_WR_U : OP_NOP;
            REQ_WR_V:
                dec.op = (32'(row_index) < MAX_MODES && 32'(col_index) < MAX_MODES)
                         ? OP_WR_V : OP_NOP;
            REQ_SAMPLE:
                dec.op = OP_SAMPLE;
            REQ_READ:
                dec.op = OP_READ;
            default:
                dec.op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (accept && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !accept)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            q_mem[wr_ptr_reg] <= dec;
    end

endmodule

### sv/svdbs_back.sv
// ----------------------------------------------------------------------------
// SVD back substitution back end
// Holds U, V, partial sums and solutions; runs the sample MAC loop and the
// V by partial-sum solve through pipelined multiply-accumulate stages.
// ----------------------------------------------------------------------------
module svdbs_back #(
    parameter int MAX_ROWS  = svdbs_pkg::MAX_ROWS_DEF,
    parameter int MAX_MODES = svdbs_pkg::MAX_MODES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  svdbs_pkg::item_t        item,
    input  logic                    item_valid,
    output logic                    pop,
    input  logic [9:0]              rows_used,
    input  logic [8:0]              modes_used,
    input  logic [4:0]              out_shift,
    output logic                    done,
    output logic signed [23:0]      x_value,
    output logic [7:0]              mode_index,
    output svdbs_pkg::back_status_t status
);
    import svdbs_pkg::*;

    localparam int MW  = $clog2(MAX_MODES);
    localparam int RAW = $clog2(MAX_ROWS);
    localparam int UAW = $clog2(MAX_ROWS * MAX_MODES);
    localparam int VAW = $clog2(MAX_MODES * MAX_MODES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SAMPLE,
        ST_SDRAIN,
        ST_SOLVE,
        ST_VDRAIN
    } state_t;

    logic signed [17:0] u_mem   [MAX_ROWS * MAX_MODES];
    logic signed [17:0] v_mem   [MAX_MODES * MAX_MODES];
    logic [47:0]        ps_mem  [MAX_MODES];
    logic [23:0]        sol_mem [MAX_MODES];

    state_t             state_reg, state_next;
    logic [MW-1:0]      j_reg, j_next;
    logic [MW-1:0]      k_reg, k_next;
    logic [MW-1:0]      clr_reg, clr_next;
    logic [MW-1:0]      nm1_reg, nm1_next;
    logic               last_row_reg, last_row_next;
    logic               first_reg, first_next;
    logic               s1_v_reg, s2_v_reg;
    logic               t1_v_reg, t2_v_reg, t3_v_reg, t4_v_reg;
    logic               rd_pend_reg, rd_pend_next;

    logic [UAW-1:0]     ubase_reg;
    logic [VAW-1:0]     vbase_reg;
    logic signed [15:0] samp_reg;
    logic [MW-1:0]      s1_j_reg, s2_j_reg;
    logic [MW-1:0]      t1_j_reg, t2_j_reg, t3_j_reg, t4_j_reg;
    logic               t1_first_reg, t1_last_reg, t2_first_reg, t2_last_reg;
    logic signed [17:0] u_rd_reg, v_rd_reg;
    logic [47:0]        ps_rd_reg;
    logic [23:0]        sol_rd_reg;
    logic signed [33:0] prod_reg;
    logic [47:0]        base_reg;
    logic signed [42:0] plo_reg;
    logic [23:0]        phi_reg;
    logic [47:0]        acc_reg;
    logic [47:0]        fin_reg;
    logic signed [47:0] sh_reg;
    logic [7:0]         mode_reg;
    logic               rd_zero_reg;

    logic [MW-1:0]      eff_nm1;
    logic [RAW-1:0]     eff_mm1;
    logic               row_ok;
    logic               start_sample;
    logic [UAW-1:0]     u_rowbase;
    logic [UAW-1:0]     u_raddr;
    logic [VAW-1:0]     v_raddr;
    logic [VAW-1:0]     v_waddr;
    logic [MW-1:0]      ps_raddr;
    logic [47:0]        prod48;
    logic [47:0]        acc_sum;
    logic signed [42:0] plo_c, phi_c;
    logic signed [33:0] prod_c;
    logic               sat_ok;
    logic [23:0]        sat_val;

    // effective sizes: zero acts as one, oversize clamps to the maximum
    always_comb
    begin
        if (modes_used == '0)
            eff_nm1 = '0;
        else if (32'(modes_used) > MAX_MODES)
            eff_nm1 = MW'(MAX_MODES - 1);
        else
            eff_nm1 = MW'(modes_used - 9'd1);
        if (rows_used == '0)
            eff_mm1 = '0;
        else if (32'(rows_used) > MAX_ROWS)
            eff_mm1 = RAW'(MAX_ROWS - 1);
        else
            eff_mm1 = RAW'(rows_used - 10'd1);
    end

    assign pop          = (state_reg == ST_IDLE) && item_valid;
    assign row_ok       = 32'(item.row) <= 32'(eff_mm1);
    assign start_sample = pop && (item.op == OP_SAMPLE) && row_ok;
    assign u_rowbase    = UAW'(item.row) * UAW'(MAX_MODES);
    assign u_raddr      = ubase_reg + UAW'(j_reg);
    assign v_raddr      = vbase_reg + VAW'(k_reg);
    assign v_waddr      = VAW'(item.row) * VAW'(MAX_MODES) + VAW'(item.col);
    assign ps_raddr     = (state_reg == ST_SOLVE) ? k_reg : j_reg;

    assign prod_c  = u_rd_reg * samp_reg;
    assign plo_c   = v_rd_reg * $signed({1'b0, ps_rd_reg[23:0]});
    assign phi_c   = v_rd_reg * $signed({1'b0, ps_rd_reg[47:24]});
    assign prod48  = {{5{plo_reg[42]}}, plo_reg} + {phi_reg, 24'd0};
    assign acc_sum = (t2_first_reg ? 48'd0 : acc_reg) + prod48;

    // saturate to 24 bits: fits when bits 47..23 all match
    assign sat_ok  = (&sh_reg[47:23]) || !(|sh_reg[47:23]);
    assign sat_val = sat_ok ? sh_reg[23:0] : (sh_reg[47] ? 24'h800000 : 24'h7FFFFF);

    assign done       = rd_pend_reg;
    assign x_value    = rd_zero_reg ? 24'sd0 : $signed(sol_rd_reg);
    assign mode_index = mode_reg;
    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.solving  = (state_reg == ST_SOLVE) || (state_reg == ST_VDRAIN);

    always_comb
    begin
        state_next    = state_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        clr_next      = clr_reg;
        nm1_next      = nm1_reg;
        last_row_next = last_row_reg;
        first_next    = first_reg;
        rd_pend_next  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MW'(MAX_MODES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start_sample)
                begin
                    state_next    = ST_SAMPLE;
                    j_next        = '0;
                    nm1_next      = eff_nm1;
                    last_row_next = (32'(item.row) == 32'(eff_mm1));
                    first_next    = (item.row == '0);
                end
                if (pop && item.op == OP_READ)
                    rd_pend_next = 1'b1;
            end
            ST_SAMPLE:
            begin
                if (j_reg == nm1_reg)
                    state_next = ST_SDRAIN;
                else
                    j_next = j_reg + 1'b1;
            end
            ST_SDRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg)
                begin
                    if (last_row_reg)
                    begin
                        state_next = ST_SOLVE;
                        j_next     = '0;
                        k_next     = '0;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_SOLVE:
            begin
                if (k_reg == nm1_reg)
                begin
                    k_next = '0;
                    if (j_reg == nm1_reg)
                        state_next = ST_VDRAIN;
                    else
                        j_next = j_reg + 1'b1;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            ST_VDRAIN:
            begin
                if (!t1_v_reg && !t2_v_reg && !t3_v_reg && !t4_v_reg)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            j_reg        <= '0;
            k_reg        <= '0;
            clr_reg      <= '0;
            nm1_reg      <= '0;
            last_row_reg <= 1'b0;
            first_reg    <= 1'b0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            t1_v_reg     <= 1'b0;
            t2_v_reg     <= 1'b0;
            t3_v_reg     <= 1'b0;
            t4_v_reg     <= 1'b0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            clr_reg      <= clr_next;
            nm1_reg      <= nm1_next;
            last_row_reg <= last_row_next;
            first_reg    <= first_next;
            s1_v_reg     <= (state_reg == ST_SAMPLE);
            s2_v_reg     <= s1_v_reg;
            t1_v_reg     <= (state_reg == ST_SOLVE);
            t2_v_reg     <= t1_v_reg;
            t3_v_reg     <= t2_v_reg && t2_last_reg;
            t4_v_reg     <= t3_v_reg;
            rd_pend_reg  <= rd_pend_next;
        end
    end

    // datapath and stores
    always_ff @(posedge clk)
    begin
        if (pop && item.op == OP_WR_U)
            u_mem[u_rowbase + UAW'(item.col)] <= item.coef;
        if (pop && item.op == OP_WR_V)
            v_mem[v_waddr] <= item.coef;
        if (start_sample)
        begin
            ubase_reg <= u_rowbase;
            samp_reg  <= item.samp;
        end
        if (state_reg == ST_SDRAIN)
            vbase_reg <= '0;
        else if (state_reg == ST_SOLVE && k_reg == nm1_reg)
            vbase_reg <= vbase_reg + VAW'(MAX_MODES);

        u_rd_reg  <= u_mem[u_raddr];
        v_rd_reg  <= v_mem[v_raddr];
        ps_rd_reg <= ps_mem[ps_raddr];

        // sample stages
        s1_j_reg <= j_reg;
        s2_j_reg <= s1_j_reg;
        prod_reg <= prod_c;
        base_reg <= first_reg ? 48'd0 : ps_rd_reg;

        // solve stages
        t1_j_reg     <= j_reg;
        t1_first_reg <= (k_reg == '0);
        t1_last_reg  <= (k_reg == nm1_reg);
        t2_j_reg     <= t1_j_reg;
        t2_first_reg <= t1_first_reg;
        t2_last_reg  <= t1_last_reg;
        plo_reg      <= plo_c;
        phi_reg      <= phi_c[23:0];
        if (t2_v_reg)
            acc_reg <= acc_sum;
        if (t2_v_reg && t2_last_reg)
        begin
            fin_reg  <= acc_sum;
            t3_j_reg <= t2_j_reg;
        end
        sh_reg   <= $signed(fin_reg) >>> out_shift;
        t4_j_reg <= t3_j_reg;

        if (state_reg == ST_CLEAR)
        begin
            ps_mem[clr_reg]  <= '0;
            sol_mem[clr_reg] <= '0;
        end
        else
        begin
            if (s2_v_reg)
                ps_mem[s2_j_reg] <= base_reg + {{14{prod_reg[33]}}, prod_reg};
            if (t4_v_reg)
                sol_mem[t4_j_reg] <= sat_val;
        end

        // read request
        if (pop && item.op == OP_READ)
        begin
            sol_rd_reg  <= sol_mem[MW'(item.col)];
            mode_reg    <= item.col;
            rd_zero_reg <= !(32'(item.col) < MAX_MODES);
        end
    end

endmodule

### verif/svd_back_substitution_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SVD back substitution testbench
// Loads U and V coefficients, streams sample frames and reads back solution
// words, checking every word against an in-bench fixed-point solver. Covers
// register bounds, ignored writes and samples, saturation, stale reads and
// sender gaps.
// ----------------------------------------------------------------------------
module svd_back_substitution_tb;
    import svdbs_pkg::*;

    localparam int NROWS  = MAX_ROWS_DEF;
    localparam int NMODES = MAX_MODES_DEF;

    typedef struct {
        logic signed [23:0] x;
        logic [7:0]         mode;
    } read_word_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         req_type;
    logic [8:0]         row_index;
    logic [7:0]         col_index;
    logic signed [17:0] coef_value;
    logic signed [15:0] sample_value;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [9:0]         cfg_data;
    logic               done;
    logic signed [23:0] x_value;
    logic [7:0]         mode_index;

    svd_back_substitution dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .row_index(row_index), .col_index(col_index),
        .coef_value(coef_value), .sample_value(sample_value),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .x_value(x_value), .mode_index(mode_index)
    );

    // solver state as the bench sees it
    logic signed [17:0] u_coef [NROWS*NMODES];
    logic signed [17:0] v_coef [NMODES*NMODES];
    bit                 u_loaded [NROWS*NMODES];
    bit                 v_loaded [NMODES*NMODES];
    logic [47:0]        col_sum [NMODES];
    logic signed [23:0] solution [NMODES];
    logic [9:0]         rows_reg;
    logic [8:0]         modes_reg;
    logic [4:0]         shift_reg;

    read_word_t pending_reads [$];
    int n_errors, n_reads_checked, n_samples, n_solves;
    int gap_pct;    // chance in a hundred of a sender gap after each word

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("%0t: timeout, %0d read words still due", $time, pending_reads.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int eff_rows();
        if (rows_reg == 0) return 1;
        return (rows_reg > NROWS) ? NROWS : int'(rows_reg);
    endfunction

    function automatic int eff_modes();
        if (modes_reg == 0) return 1;
        return (modes_reg > NMODES) ? NMODES : int'(modes_reg);
    endfunction

    // a sample may only go out if every coefficient it touches has been loaded
    function automatic bit sample_is_safe(int row);
        int m, n;
        m = eff_rows();
        n = eff_modes();
        if (row >= m) return 1;     // dropped by the block, touches nothing
        for (int j = 0; j < n; j++)
            if (!u_loaded[row*NMODES + j]) return 0;
        if (row == m - 1)
            for (int i = 0; i < n*n; i++)
                if (!v_loaded[(i / n)*NMODES + (i % n)]) return 0;
        return 1;
    endfunction

    // x = V * col_sum, shift, saturate
    function automatic void solve_modes(int n);
        logic [47:0]        acc;
        logic signed [47:0] vx, val, r;
        for (int j = 0; j < n; j++)
        begin
            acc = '0;
            for (int k = 0; k < n; k++)
            begin
                vx  = 48'(v_coef[j*NMODES + k]);
                acc = acc + vx * col_sum[k];
            end
            val = acc;
            r   = val >>> shift_reg;
            if (r > 48'sd8388607)       r = 48'sd8388607;
            else if (r < -48'sd8388608) r = -48'sd8388608;
            solution[j] = r[23:0];
        end
        n_solves++;
    endfunction

    function automatic void predict_word(logic [1:0] req, logic [8:0] row, logic [7:0] col,
                                         logic signed [17:0] coef, logic signed [15:0] samp);
        logic signed [47:0] prod;
        read_word_t         rw;
        int                 m, n;
        m = eff_rows();
        n = eff_modes();
        case (req)
            REQ_WR_U:
            begin
                u_coef[row*NMODES + col]   = coef;
                u_loaded[row*NMODES + col] = 1;
            end
            REQ_WR_V:
                if (row < NMODES)
                begin
                    v_coef[row*NMODES + col]   = coef;
                    v_loaded[row*NMODES + col] = 1;
                end
            REQ_SAMPLE:
                if (row < m)
                begin
                    n_samples++;
                    for (int j = 0; j < n; j++)
                    begin
                        prod       = 48'(u_coef[row*NMODES + j]) * 48'(samp);
                        col_sum[j] = ((row == 0) ? 48'd0 : col_sum[j]) + prod;
                    end
                    if (row == m - 1) solve_modes(n);
                end
            default:
            begin
                rw.x    = solution[col];
                rw.mode = col;
                pending_reads.push_back(rw);
            end
        endcase
    endfunction

    // result checker: done is a one-cycle strobe, taken at the edge ending it
    always @(posedge clk)
    begin
        read_word_t exp_w;
        if (rst_n && done)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: unexpected word x=%0d mode=%0d", $time, x_value, mode_index);
                n_errors++;
            end
            else
            begin
                exp_w = pending_reads.pop_front();
                n_reads_checked++;
                if (x_value !== exp_w.x)
                begin
                    $display("%0t: x_value mismatch, expected %0d, got %0d (mode %0d)",
                             $time, exp_w.x, x_value, exp_w.mode);
                    n_errors++;
                end
                if (mode_index !== exp_w.mode)
                begin
                    $display("%0t: mode_index mismatch, expected %0d, got %0d",
                             $time, exp_w.mode, mode_index);
                    n_errors++;
                end
            end
        end
    end

    function automatic logic signed [17:0] pick_coef();
        case ($urandom % 8)
            0:       return -18'sd131072;
            1:       return 18'sd131071;
            2:       return 18'($urandom_range(0, 63)) - 18'sd32;
            default: return 18'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom % 8)
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'($urandom_range(0, 31)) - 16'sd16;
            default: return 16'($urandom);
        endcase
    endfunction

    // one word: held until taken, then an optional sender gap
    task automatic send_word(logic [1:0] req, logic [8:0] row, logic [7:0] col,
                             logic signed [17:0] coef, logic signed [15:0] samp);
        start        <= 1'b1;
        req_type     <= req;
        row_index    <= row;
        col_index    <= col;
        coef_value   <= coef;
        sample_value <= samp;
        do @(posedge clk); while (busy);
        predict_word(req, row, col, coef, samp);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic load_u(int row, int col, logic signed [17:0] c);
        send_word(REQ_WR_U, 9'(row), 8'(col), c, pick_sample());
    endtask

    task automatic load_v(int row, int col, logic signed [17:0] c);
        send_word(REQ_WR_V, 9'(row), 8'(col), c, pick_sample());
    endtask

    task automatic sample_row(int row, logic signed [15:0] s);
        send_word(REQ_SAMPLE, 9'(row), 8'($urandom), pick_coef(), s);
    endtask

    task automatic read_mode(int col);
        send_word(REQ_READ, 9'($urandom), 8'(col), pick_coef(), pick_sample());
    endtask

    // wait for the block to go quiet, then write all three registers;
    // up to five words may still be in flight, each possibly a full solve
    task automatic write_regs(int rows, int modes, int shift);
        int n, drain;
        start <= 1'b0;
        while (pending_reads.size() != 0) @(posedge clk);
        n     = eff_modes();
        drain = 5*(n*n + n + 9) + 20;
        repeat (drain) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROWS;
        cfg_data  <= 10'(rows);
        @(posedge clk);
        cfg_index <= CFG_MODES;
        cfg_data  <= 10'(modes);
        @(posedge clk);
        cfg_index <= CFG_SHIFT;
        cfg_data  <= 10'(shift);
        @(posedge clk);
        cfg_we    <= 1'b0;
        rows_reg  = 10'(rows);
        modes_reg = 9'(modes);
        shift_reg = 5'(shift);
    endtask

    // single-row frames: extremes, saturation, dropped writes and samples
    task automatic test_single_row();
        write_regs(1, 1, 0);
        load_u(0, 0, 18'sd131071);
        load_v(0, 0, -18'sd131072);
        sample_row(0, -16'sd32768);          // starts and solves in one go
        read_mode(0);
        read_mode(255);                      // never solved, still zero
        load_u(511, 255, -18'sd131072);
        load_v(300, 7, 18'sd131071);         // V row out of range, dropped
        sample_row(3, 16'sd32767);           // beyond rows_used, dropped
        read_mode(0);
        write_regs(1, 1, 31);
        sample_row(0, 16'sd32767);
        read_mode(0);
        load_u(0, 0, 18'sd1);
        load_v(0, 0, 18'sd1);
        write_regs(1, 1, 0);
        sample_row(0, -16'sd1);              // small negative, no saturation
        read_mode(0);
    endtask

    // zero acts as one, oversize acts as the maximum
    task automatic test_register_bounds();
        write_regs(0, 0, 3);
        sample_row(0, pick_sample());
        read_mode(0);
        read_mode(1);
        write_regs(1023, 511, 14);
        read_mode(0);
        read_mode(200);
        read_mode(255);
    endtask

    // all 256 modes in use; only row 0 loaded so no solve is ever run
    task automatic test_wide_modes();
        write_regs(2, 256, 5);
        for (int j = 0; j < NMODES; j++) load_u(0, j, pick_coef());
        for (int i = 0; i < 40; i++)
            if ($urandom % 2) sample_row(0, pick_sample());
            else read_mode($urandom);
    endtask

    // loaded rows, then mostly in-order frames with reads, some noise
    task automatic test_random_frames(int rows, int modes, int shift, int words, int gap);
        int m, n, frame_row, r, row;
        gap_pct = gap;
        write_regs(rows, modes, shift);
        m = eff_rows();
        n = eff_modes();
        for (int i = 0; i < m; i++)
            if (m*n <= 64 || i < 2 || i >= m - 2)
                for (int j = 0; j < n; j++) load_u(i, j, pick_coef());
        if (n <= 8)
            for (int i = 0; i < n*n; i++) load_v(i / n, i % n, pick_coef());
        frame_row = 0;
        for (int w = 0; w < words; w++)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                read_mode(($urandom % 4 == 0) ? $urandom_range(0, 255) : $urandom_range(0, n-1));
            else if (r < 80)
            begin
                // well-formed frame, skipping rows whose U or V coefficients were never loaded
                while (!sample_is_safe(frame_row)) frame_row = (frame_row + 1) % m;
                sample_row(frame_row, pick_sample());
                frame_row = (frame_row + 1) % m;
            end
            else if (r < 88)
                load_u($urandom_range(0, 511), $urandom_range(0, 255), pick_coef());
            else if (r < 93)
                load_v($urandom_range(0, 511), $urandom_range(0, 255), pick_coef());
            else
            begin
                row = $urandom_range(0, 511);   // stray or out-of-order sample
                if (sample_is_safe(row)) sample_row(row, pick_sample());
                else read_mode($urandom);
            end
        end
    endtask

    initial
    begin
        int drain;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        req_type     <= REQ_READ;
        row_index    <= '0;
        col_index    <= '0;
        coef_value   <= '0;
        sample_value <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_ROWS;
        cfg_data     <= '0;
        for (int i = 0; i < NMODES; i++)
        begin
            col_sum[i]  = '0;
            solution[i] = '0;
        end
        rows_reg  = 10'd512;
        modes_reg = 9'd256;
        shift_reg = 5'd14;
        gap_pct   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_single_row();
        test_register_bounds();
        test_random_frames(4, 3, 14, 260, 0);
        test_random_frames(1, 4, 0, 200, 83);
        test_random_frames(8, 8, 31, 260, 0);
        test_random_frames(512, 2, 20, 220, 10);
        test_random_frames(3, 5, 9, 150, 83);
        test_wide_modes();

        start <= 1'b0;
        while (pending_reads.size() != 0) @(posedge clk);
        drain = 5*(eff_modes() + 3) + 20;
        repeat (drain) @(posedge clk);

        $display("Covered %0d samples, %0d solves, %0d read words checked,",
                 n_samples, n_solves, n_reads_checked);
        $display("over single-row, bounded, wide and random frame settings.");
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
